/* sv/bit_group_repacker_core_defines.svh */
// Assertion macros shared by the repacker modules.
// Needs clk and rst_n in the scope of each use.
`ifndef BIT_GROUP_REPACKER_CORE_DEFINES_SVH
`define BIT_GROUP_REPACKER_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define BGR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define BGR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define BGR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/bgr_pkg.sv */
// Shared types, codes and helpers of the bit group repacker.
// No dependencies; used by every module of the block.
`default_nettype none
package bgr_pkg;

  localparam int unsigned AccW  = 16;
  localparam int unsigned PendW = 5;
  localparam int unsigned SymW  = 8;
  localparam int unsigned WidW  = 4;
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  localparam logic [WidW-1:0] InBitsRst  = 4'd8;
  localparam logic [WidW-1:0] OutBitsRst = 4'd5;
  localparam logic            PadRst     = 1'b1;

  typedef enum logic [1:0] {
    REG_IN_BITS  = 2'd0,
    REG_OUT_BITS = 2'd1,
    REG_PAD_MODE = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_GROUP = 2'd1,
    S_END   = 2'd2,
    S_STAT  = 2'd3
  } state_t;

  typedef struct packed {
    logic [WidW-1:0] in_bits;
    logic [WidW-1:0] out_bits;
    logic            pad_mode;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic emit_group;
    logic emit_left;
    logic emit_stat;
  } cmd_t;

  typedef struct packed {
    logic has_group;
    logic last_group;
    logic pend_nz;
    logic pad;
    logic out_free;
  } sts_t;

  // Clamp a width register to 1..8.
  function automatic logic [WidW-1:0] eff_width(input logic [WidW-1:0] v);
    logic [WidW-1:0] r;
    r = v;
    if (v == '0) begin
      r = 4'd1;
    end else if (v > 4'd8) begin
      r = 4'd8;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* sv/bgr_regs.sv */
// Configuration registers behind the APB-style write port.
// Depends on bgr_pkg.
`default_nettype none
module bgr_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [bgr_pkg::AddrW-1:0]  cfg_paddr,
  input  wire logic [bgr_pkg::DataW-1:0]  cfg_pwdata,
  output logic      [bgr_pkg::DataW-1:0]  cfg_prdata,
  output logic                            cfg_pready,
  output bgr_pkg::cfg_t                   cfg,
  output logic                            msg_clear
);

  logic [bgr_pkg::WidW-1:0] in_bits_r, in_bits_nxt;
  logic [bgr_pkg::WidW-1:0] out_bits_r, out_bits_nxt;
  logic                     pad_mode_r, pad_mode_nxt;
  logic                     wr_en;
  bgr_pkg::reg_idx_t        idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign idx        = bgr_pkg::reg_idx_t'(cfg_paddr[3:2]);

  always_comb begin
    in_bits_nxt  = in_bits_r;
    out_bits_nxt = out_bits_r;
    pad_mode_nxt = pad_mode_r;
    msg_clear    = 1'b0;
    if (wr_en) begin
      case (idx)
        bgr_pkg::REG_IN_BITS: begin
          in_bits_nxt = cfg_pwdata[bgr_pkg::WidW-1:0];
          msg_clear   = 1'b1;
        end
        bgr_pkg::REG_OUT_BITS: begin
          out_bits_nxt = cfg_pwdata[bgr_pkg::WidW-1:0];
          msg_clear    = 1'b1;
        end
        bgr_pkg::REG_PAD_MODE: begin
          pad_mode_nxt = cfg_pwdata[0];
        end
        default: begin
          // unmapped address: drop the write
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      bgr_pkg::REG_IN_BITS:  cfg_prdata = bgr_pkg::DataW'(in_bits_r);
      bgr_pkg::REG_OUT_BITS: cfg_prdata = bgr_pkg::DataW'(out_bits_r);
      bgr_pkg::REG_PAD_MODE: cfg_prdata = bgr_pkg::DataW'(pad_mode_r);
      default:               cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_bits_r  <= bgr_pkg::InBitsRst;
      out_bits_r <= bgr_pkg::OutBitsRst;
      pad_mode_r <= bgr_pkg::PadRst;
    end else begin
      in_bits_r  <= in_bits_nxt;
      out_bits_r <= out_bits_nxt;
      pad_mode_r <= pad_mode_nxt;
    end
  end

  assign cfg.in_bits  = bgr_pkg::eff_width(in_bits_r);
  assign cfg.out_bits = bgr_pkg::eff_width(out_bits_r);
  assign cfg.pad_mode = pad_mode_r;

endmodule
`default_nettype wire

/* sv/bgr_dp.sv */
// Datapath: bit accumulator, group extraction and the output word register.
// Depends on bgr_pkg and bit_group_repacker_core_defines.svh.
`default_nettype none
`include "bit_group_repacker_core_defines.svh"
module bgr_dp (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire bgr_pkg::cfg_t             cfg,
  input  wire logic                      msg_clear,
  input  wire bgr_pkg::cmd_t             cmd,
  output bgr_pkg::sts_t                  sts,
  input  wire logic [bgr_pkg::SymW-1:0]  in_symbol_in,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic      [bgr_pkg::SymW-1:0]  out_symbol,
  output logic                           out_is_status,
  output logic                           out_ok,
  output logic                           out_last
);

  logic [bgr_pkg::AccW-1:0]  acc_r, acc_nxt;
  logic [bgr_pkg::PendW-1:0] pend_r, pend_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [bgr_pkg::SymW-1:0]  out_symbol_r, out_symbol_nxt;
  logic                      out_is_status_r, out_is_status_nxt;
  logic                      out_ok_r, out_ok_nxt;
  logic                      out_last_r, out_last_nxt;

  logic [bgr_pkg::PendW-1:0] ob_ext, ib_ext, rem;
  logic [bgr_pkg::SymW-1:0]  in_mask, maxv, group_sym, leftover;
  logic [bgr_pkg::WidW-1:0]  sh;
  logic [bgr_pkg::AccW-1:0]  acc_shl, left_full;
  logic                      ok_calc;

  assign ob_ext    = bgr_pkg::PendW'(cfg.out_bits);
  assign ib_ext    = bgr_pkg::PendW'(cfg.in_bits);
  assign in_mask   = bgr_pkg::SymW'((9'd1 << cfg.in_bits) - 9'd1);
  assign maxv      = bgr_pkg::SymW'((9'd1 << cfg.out_bits) - 9'd1);
  assign rem       = pend_r - ob_ext;
  assign acc_shl   = acc_r >> rem;
  assign group_sym = acc_shl[bgr_pkg::SymW-1:0] & maxv;

  // Left-align leftover bits into one out_bits group, zero filled.
  assign sh        = (pend_r < ob_ext) ? bgr_pkg::WidW'(ob_ext - pend_r) : '0;
  assign left_full = acc_r << sh;
  assign leftover  = left_full[bgr_pkg::SymW-1:0] & maxv;
  assign ok_calc   = cfg.pad_mode | ((leftover == '0) && (pend_r < ib_ext));

  assign sts.has_group  = (pend_r >= ob_ext);
  assign sts.last_group = (rem < ob_ext);
  assign sts.pend_nz    = (pend_r != '0);
  assign sts.pad        = cfg.pad_mode;
  assign sts.out_free   = ~out_valid_r | out_ready;

  always_comb begin
    acc_nxt  = acc_r;
    pend_nxt = pend_r;
    if (msg_clear || cmd.emit_left || cmd.emit_stat) begin
      acc_nxt  = '0;
      pend_nxt = '0;
    end else if (cmd.load) begin
      acc_nxt  = (acc_r << cfg.in_bits) | bgr_pkg::AccW'(in_symbol_in & in_mask);
      pend_nxt = pend_r + ib_ext;
    end else if (cmd.emit_group) begin
      acc_nxt  = acc_r & bgr_pkg::AccW'((17'd1 << rem) - 17'd1);
      pend_nxt = rem;
    end
  end

  always_comb begin
    out_valid_nxt     = out_valid_r & ~out_ready;
    out_symbol_nxt    = out_symbol_r;
    out_is_status_nxt = out_is_status_r;
    out_ok_nxt        = out_ok_r;
    out_last_nxt      = out_last_r;
    if (cmd.emit_group) begin
      out_valid_nxt     = 1'b1;
      out_symbol_nxt    = group_sym;
      out_is_status_nxt = 1'b0;
      out_ok_nxt        = 1'b0;
      out_last_nxt      = sts.last_group;
    end else if (cmd.emit_left) begin
      out_valid_nxt     = 1'b1;
      out_symbol_nxt    = leftover;
      out_is_status_nxt = 1'b0;
      out_ok_nxt        = 1'b0;
      out_last_nxt      = 1'b0;
    end else if (cmd.emit_stat) begin
      out_valid_nxt     = 1'b1;
      out_symbol_nxt    = '0;
      out_is_status_nxt = 1'b1;
      out_ok_nxt        = ok_calc;
      out_last_nxt      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_symbol_r    <= out_symbol_nxt;
    out_is_status_r <= out_is_status_nxt;
    out_ok_r        <= out_ok_nxt;
    out_last_r      <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_symbol    = out_symbol_r;
  assign out_is_status = out_is_status_r;
  assign out_ok        = out_ok_r;
  assign out_last      = out_last_r;

  `BGR_ASSERT(a_acc_clean, (acc_r >> pend_r) == '0, "accumulator holds bits above pending count")
  `BGR_ASSERT_NEXT(a_stat_clears, cmd.emit_stat, (pend_r == '0) && (acc_r == '0), "status did not clear message")
  `BGR_ASSERT_IMP(a_emit_free, cmd.emit_group || cmd.emit_left || cmd.emit_stat, ~out_valid_r || out_ready, "word overwritten before taken")

endmodule
`default_nettype wire

/* sv/bgr_ctrl.sv */
// Controller state machine: accepts input words and sequences result emission.
// Depends on bgr_pkg and bit_group_repacker_core_defines.svh.
`default_nettype none
`include "bit_group_repacker_core_defines.svh"
module bgr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          in_kind,
  input  wire bgr_pkg::sts_t sts,
  output bgr_pkg::cmd_t      cmd
);

  bgr_pkg::state_t state_r, state_nxt;
  logic            pad_sym;

  assign pad_sym = sts.pad & sts.pend_nz;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bgr_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = in_kind ? bgr_pkg::S_END : bgr_pkg::S_GROUP;
        end
      end
      bgr_pkg::S_GROUP: begin
        if (!sts.has_group) begin
          state_nxt = bgr_pkg::S_IDLE;
        end else if (sts.out_free && sts.last_group) begin
          state_nxt = bgr_pkg::S_IDLE;
        end
      end
      bgr_pkg::S_END: begin
        if (sts.out_free) begin
          state_nxt = pad_sym ? bgr_pkg::S_STAT : bgr_pkg::S_IDLE;
        end
      end
      bgr_pkg::S_STAT: begin
        if (sts.out_free) begin
          state_nxt = bgr_pkg::S_IDLE;
        end
      end
      default: state_nxt = bgr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      bgr_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid & ~in_kind;
      end
      bgr_pkg::S_GROUP: begin
        cmd.emit_group = sts.has_group & sts.out_free;
      end
      bgr_pkg::S_END: begin
        cmd.emit_left = sts.out_free & pad_sym;
        cmd.emit_stat = sts.out_free & ~pad_sym;
      end
      bgr_pkg::S_STAT: begin
        cmd.emit_stat = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bgr_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `BGR_ASSERT(a_cmd_onehot, $onehot0(cmd), "more than one datapath command")
  `BGR_ASSERT_NEXT(a_busy_after_load, cmd.load, !in_ready, "accepted a word while one is in work")
  `BGR_ASSERT_IMP(a_no_emit_idle, in_ready, !(cmd.emit_group || cmd.emit_left || cmd.emit_stat), "emit while idle")

endmodule
`default_nettype wire

/* sv/bit_group_repacker_core.sv */
// Top level of the bit group repacker: wires registers, controller and datapath.
// Depends on bgr_pkg, bgr_regs, bgr_ctrl and bgr_dp.
//
// Usage:
//   Input channel (in_valid/in_ready, in_kind, in_symbol_in): a data word
//   (in_kind 0) shifts its low in_bits bits into the accumulator; an end word
//   (in_kind 1) closes the message. Result channel (out_valid/out_ready) gives
//   out_bits-wide groups MSB first, then on an end word an optional padded
//   leftover group and one status word (out_is_status, out_ok). out_last flags
//   the final result of each input word.
//   Timing: the word is taken in the idle state, then one result per cycle
//   comes from the controller while the output register is free; a new word
//   is taken only once the controller is back in its idle state. The first
//   result shows on out_valid once the group or end state has loaded it.
//   A waiting last result does not block the next input word; when the receiver
//   stalls, the controller holds in its emit state and in_ready stays low until
//   the last result of the word is loaded into the output register.
//   Reset (synchronous, rst_n low) restores in_bits 8, out_bits 5, pad mode
//   on and clears the message. Writing in_bits or out_bits drops any partial
//   message; write registers only while the block is idle.
`default_nettype none
module bit_group_repacker_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_psel,
  input  wire logic                      cfg_penable,
  input  wire logic                      cfg_pwrite,
  input  wire logic [bgr_pkg::AddrW-1:0] cfg_paddr,
  input  wire logic [bgr_pkg::DataW-1:0] cfg_pwdata,
  output logic      [bgr_pkg::DataW-1:0] cfg_prdata,
  output logic                           cfg_pready,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      in_kind,
  input  wire logic [bgr_pkg::SymW-1:0]  in_symbol_in,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic      [bgr_pkg::SymW-1:0]  out_symbol,
  output logic                           out_is_status,
  output logic                           out_ok,
  output logic                           out_last
);

  bgr_pkg::cfg_t cfg;
  bgr_pkg::cmd_t cmd;
  bgr_pkg::sts_t sts;
  logic          msg_clear;

  // Register file; a width write also pulses msg_clear.
  bgr_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg),
    .msg_clear   (msg_clear)
  );

  // Sequencer: takes one word, then issues one emit per free output slot.
  bgr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_kind  (in_kind),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Accumulator, group extraction and output word register.
  bgr_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .msg_clear     (msg_clear),
    .cmd           (cmd),
    .sts           (sts),
    .in_symbol_in  (in_symbol_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_symbol    (out_symbol),
    .out_is_status (out_is_status),
    .out_ok        (out_ok),
    .out_last      (out_last)
  );

endmodule
`default_nettype wire
